// File: src/dfb_pkg.sv
// Shared constants and types for the fixed block dedup counter.
package dfb_pkg;

    localparam int CFG_W    = 13;
    localparam int BYTE_W   = 8;
    localparam int UCOUNT_W = 7;
    localparam int TOTAL_W  = 32;
    localparam int BLEN_W   = 13;

    localparam logic [CFG_W-1:0]   BLOCK_SIZE_RST = 13'd4096;
    localparam logic [TOTAL_W-1:0] TOTAL_MAX      = 32'hFFFF_FFFF;

    typedef struct packed {
        logic done;
        logic dup;
    } scan_result_t;

endpackage

// File: src/dfb_ram.sv
// Generic simple dual-port RAM with registered read.
module dfb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// File: src/dfb_scan.sv
// Per-byte sweep over stored unique blocks: store, lengths and running match flags.
module dfb_scan import dfb_pkg::*; #(
    parameter int BLOCK_BYTES = 4096,
    parameter int MAX_UNIQUE  = 64
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  start,
    input  logic [$clog2(BLOCK_BYTES)-1:0]        start_pos,
    input  logic [BYTE_W-1:0]                     start_byte,
    input  logic                                  start_eob,
    input  logic [$clog2(BLOCK_BYTES+1)-1:0]      start_len,
    input  logic [$clog2(MAX_UNIQUE+1)-1:0]       start_count,
    input  logic                                  commit,
    output scan_result_t                          status
);

    localparam int POS_W  = $clog2(BLOCK_BYTES);
    localparam int FILL_W = $clog2(BLOCK_BYTES + 1);
    localparam int IDX_W  = $clog2(MAX_UNIQUE);
    localparam int CNT_W  = $clog2(MAX_UNIQUE + 1);
    localparam int STORE_DEPTH = (2 ** IDX_W) * (2 ** POS_W);

    typedef enum logic [1:0] {
        SC_IDLE,
        SC_SWEEP,
        SC_DRAIN
    } sc_state_t;

    sc_state_t          state_reg,  state_next;
    logic [IDX_W-1:0]   idx_reg,    idx_next;
    logic [IDX_W-1:0]   ent_reg,    ent_next;
    logic [CNT_W-1:0]   cnt_reg,    cnt_next;
    logic [POS_W-1:0]   pos_reg,    pos_next;
    logic [BYTE_W-1:0]  byte_reg,   byte_next;
    logic               eob_reg,    eob_next;
    logic [FILL_W-1:0]  len_reg,    len_next;
    logic               rd_vld_reg, rd_vld_next;
    logic               dup_reg,    dup_next;
    logic               done_reg,   done_next;

    logic [BYTE_W-1:0]  store_q;
    logic [FILL_W-1:0]  elen_q;
    logic               flag_q;
    logic               hit;
    logic               store_we;

    assign store_we = start && (state_reg == SC_IDLE)
                      && (start_count < CNT_W'(MAX_UNIQUE));

    dfb_ram #(.WIDTH(BYTE_W), .DEPTH(STORE_DEPTH)) u_store (
        .aclk    (aclk),
        .wr_en   (store_we),
        .wr_addr ({start_count[IDX_W-1:0], start_pos}),
        .wr_data (start_byte),
        .rd_addr ({idx_reg, pos_reg}),
        .rd_data (store_q)
    );

    dfb_ram #(.WIDTH(FILL_W), .DEPTH(MAX_UNIQUE)) u_lengths (
        .aclk    (aclk),
        .wr_en   (commit),
        .wr_addr (cnt_reg[IDX_W-1:0]),
        .wr_data (len_reg),
        .rd_addr (idx_reg),
        .rd_data (elen_q)
    );

    dfb_ram #(.WIDTH(1), .DEPTH(MAX_UNIQUE)) u_flags (
        .aclk    (aclk),
        .wr_en   (rd_vld_reg),
        .wr_addr (ent_reg),
        .wr_data (hit),
        .rd_addr (idx_reg),
        .rd_data (flag_q)
    );

    // Entry still matches if all earlier bytes matched and this one is within its length
    assign hit = ((pos_reg == '0) || flag_q)
                 && (32'(pos_reg) < 32'(elen_q))
                 && (byte_reg == store_q);

    always_comb begin
        state_next  = state_reg;
        idx_next    = idx_reg;
        ent_next    = ent_reg;
        cnt_next    = cnt_reg;
        pos_next    = pos_reg;
        byte_next   = byte_reg;
        eob_next    = eob_reg;
        len_next    = len_reg;
        dup_next    = dup_reg;
        rd_vld_next = 1'b0;
        done_next   = 1'b0;

        if (rd_vld_reg && eob_reg && hit && (elen_q == len_reg)) begin
            dup_next = 1'b1;
        end

        case (state_reg)
            SC_IDLE: begin
                if (start) begin
                    pos_next  = start_pos;
                    byte_next = start_byte;
                    eob_next  = start_eob;
                    len_next  = start_len;
                    cnt_next  = start_count;
                    dup_next  = 1'b0;
                    idx_next  = '0;
                    if (start_count == '0) begin
                        done_next = 1'b1;
                    end else begin
                        state_next = SC_SWEEP;
                    end
                end
            end
            SC_SWEEP: begin
                rd_vld_next = 1'b1;
                ent_next    = idx_reg;
                if (CNT_W'(idx_reg) + CNT_W'(1) == cnt_reg) begin
                    state_next = SC_DRAIN;
                end else begin
                    idx_next = idx_reg + IDX_W'(1);
                end
            end
            SC_DRAIN: begin
                done_next  = 1'b1;
                state_next = SC_IDLE;
            end
            default: begin
                state_next = SC_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= SC_IDLE;
            rd_vld_reg <= 1'b0;
            done_reg   <= 1'b0;
            dup_reg    <= 1'b0;
        end else begin
            state_reg  <= state_next;
            rd_vld_reg <= rd_vld_next;
            done_reg   <= done_next;
            dup_reg    <= dup_next;
        end
        idx_reg  <= idx_next;
        ent_reg  <= ent_next;
        cnt_reg  <= cnt_next;
        pos_reg  <= pos_next;
        byte_reg <= byte_next;
        eob_reg  <= eob_next;
        len_reg  <= len_next;
    end

    assign status.done = done_reg;
    assign status.dup  = dup_reg;

endmodule

// File: src/fixed_block_dedup_counter_unit.sv
// Top level of the fixed block dedup counter: block assembly, counters and result register.
//
// Input channel s_*: one item is one byte of the stream plus an end-of-data flag.
// Result channel m_*: one item per completed block (block_size bytes, 0 read as 1
// and values above BLOCK_BYTES as BLOCK_BYTES, or cut short by end of data):
// duplicate flag, unique and total counts, length, table-full flag.
// cfg_wr_en/cfg_wr_data write block_size; write it only while the block is idle.
// Each byte is compared against every stored unique block, one entry per cycle,
// by one shared compare unit reading the block store RAM. With no block stored
// yet the sweep is skipped. When a byte closes a block, a finish step follows
// before the next byte is taken.
// s_ready is low while an item is in work.
// A finished result waits in the output register; the next byte is still taken,
// and only the close of a further block waits for m_ready.
// Reset clears the counters, the fill count and block_size (to 4096); the block
// store needs no clearing pass since only written entries are ever compared.
module fixed_block_dedup_counter_unit import dfb_pkg::*; #(
    parameter int BLOCK_BYTES = 4096,
    parameter int MAX_UNIQUE  = 64
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [BYTE_W-1:0]    s_data_byte,
    input  logic                 s_end_of_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic                 m_is_duplicate,
    output logic [UCOUNT_W-1:0]  m_unique_count,
    output logic [TOTAL_W-1:0]   m_total_blocks,
    output logic [BLEN_W-1:0]    m_block_length,
    output logic                 m_table_full,
    input  logic                 cfg_wr_en,
    input  logic [CFG_W-1:0]     cfg_wr_data
);

    localparam int POS_W  = $clog2(BLOCK_BYTES);
    localparam int FILL_W = $clog2(BLOCK_BYTES + 1);
    localparam int CNT_W  = $clog2(MAX_UNIQUE + 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } state_t;

    state_t              state_reg,  state_next;
    logic [CFG_W-1:0]    bsize_reg,  bsize_next;
    logic [FILL_W-1:0]   fill_reg,   fill_next;
    logic [FILL_W-1:0]   len_reg,    len_next;
    logic                eob_reg,    eob_next;
    logic [CNT_W-1:0]    stored_reg, stored_next;
    logic [TOTAL_W-1:0]  total_reg,  total_next;
    logic                m_valid_reg,  m_valid_next;
    logic                m_dup_reg,    m_dup_next;
    logic [UCOUNT_W-1:0] m_ucnt_reg,   m_ucnt_next;
    logic [TOTAL_W-1:0]  m_total_reg,  m_total_next;
    logic [BLEN_W-1:0]   m_blen_reg,   m_blen_next;
    logic                m_full_reg,   m_full_next;

    logic [31:0]         eff_size;
    logic [FILL_W-1:0]   fill_after;
    logic                blk_end;
    logic                accept;
    logic                commit;
    scan_result_t        scan_status;

    assign accept = s_valid && s_ready;
    assign s_ready = (state_reg == ST_IDLE);

    always_comb begin
        if (bsize_reg == '0) begin
            eff_size = 32'd1;
        end else if (32'(bsize_reg) > 32'(BLOCK_BYTES)) begin
            eff_size = 32'(BLOCK_BYTES);
        end else begin
            eff_size = 32'(bsize_reg);
        end
    end

    assign fill_after = (32'(fill_reg) < 32'(BLOCK_BYTES)) ? fill_reg + FILL_W'(1) : fill_reg;
    assign blk_end    = s_end_of_data || (32'(fill_after) >= eff_size);

    dfb_scan #(.BLOCK_BYTES(BLOCK_BYTES), .MAX_UNIQUE(MAX_UNIQUE)) u_scan (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .start       (accept),
        .start_pos   (fill_reg[POS_W-1:0]),
        .start_byte  (s_data_byte),
        .start_eob   (blk_end),
        .start_len   (fill_after),
        .start_count (stored_reg),
        .commit      (commit),
        .status      (scan_status)
    );

    always_comb begin
        state_next   = state_reg;
        bsize_next   = bsize_reg;
        fill_next    = fill_reg;
        len_next     = len_reg;
        eob_next     = eob_reg;
        stored_next  = stored_reg;
        total_next   = total_reg;
        m_valid_next = m_valid_reg;
        m_dup_next   = m_dup_reg;
        m_ucnt_next  = m_ucnt_reg;
        m_total_next = m_total_reg;
        m_blen_next  = m_blen_reg;
        m_full_next  = m_full_reg;
        commit       = 1'b0;

        if (cfg_wr_en) begin
            bsize_next = cfg_wr_data;
        end
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    len_next   = fill_after;
                    eob_next   = blk_end;
                    fill_next  = blk_end ? '0 : fill_after;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (scan_status.done) begin
                    state_next = eob_reg ? ST_FINISH : ST_IDLE;
                end
            end
            ST_FINISH: begin
                if (!m_valid_reg || m_ready) begin
                    m_full_next = 1'b0;
                    if (!scan_status.dup) begin
                        if (stored_reg < CNT_W'(MAX_UNIQUE)) begin
                            commit      = 1'b1;
                            stored_next = stored_reg + CNT_W'(1);
                        end else begin
                            m_full_next = 1'b1;
                        end
                    end
                    if (total_reg != TOTAL_MAX) begin
                        total_next = total_reg + TOTAL_W'(1);
                    end
                    m_valid_next = 1'b1;
                    m_dup_next   = scan_status.dup;
                    m_ucnt_next  = UCOUNT_W'(stored_next);
                    m_total_next = total_next;
                    m_blen_next  = BLEN_W'(len_reg);
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            bsize_reg   <= BLOCK_SIZE_RST;
            fill_reg    <= '0;
            stored_reg  <= '0;
            total_reg   <= '0;
            m_valid_reg <= 1'b0;
            eob_reg     <= 1'b0;
        end else begin
            state_reg   <= state_next;
            bsize_reg   <= bsize_next;
            fill_reg    <= fill_next;
            stored_reg  <= stored_next;
            total_reg   <= total_next;
            m_valid_reg <= m_valid_next;
            eob_reg     <= eob_next;
        end
        len_reg     <= len_next;
        m_dup_reg   <= m_dup_next;
        m_ucnt_reg  <= m_ucnt_next;
        m_total_reg <= m_total_next;
        m_blen_reg  <= m_blen_next;
        m_full_reg  <= m_full_next;
    end

    assign m_valid        = m_valid_reg;
    assign m_is_duplicate = m_dup_reg;
    assign m_unique_count = m_ucnt_reg;
    assign m_total_blocks = m_total_reg;
    assign m_block_length = m_blen_reg;
    assign m_table_full   = m_full_reg;

endmodule

// File: tb/tb_fixed_block_dedup_counter_unit.sv
// Testbench for fixed_block_dedup_counter_unit: random byte streams checked against a block dedup predictor.
module tb_fixed_block_dedup_counter_unit import dfb_pkg::*;;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int BLOCK_BYTES  = 4096;
    localparam int MAX_UNIQUE   = 64;
    localparam int DRAIN_CYCLES = MAX_UNIQUE + 8;
    localparam int HOLD_CYCLES  = 300;
    localparam int LIMIT        = 2_000_000;
    localparam int LIB_N        = 24;
    localparam int LIB_LEN      = 64;
    localparam int SHORT_LEN    = 100;

    typedef struct {
        logic                dup;
        logic [UCOUNT_W-1:0] uniq;
        logic [TOTAL_W-1:0]  total;
        logic [BLEN_W-1:0]   blen;
        logic                full;
    } blk_result_t;

    logic                aclk = 1'b0;
    logic                aresetn;
    logic                s_valid;
    logic                s_ready;
    logic [BYTE_W-1:0]   s_data_byte;
    logic                s_end_of_data;
    logic                m_valid;
    logic                m_ready;
    logic                m_is_duplicate;
    logic [UCOUNT_W-1:0] m_unique_count;
    logic [TOTAL_W-1:0]  m_total_blocks;
    logic [BLEN_W-1:0]   m_block_length;
    logic                m_table_full;
    logic                cfg_wr_en;
    logic [CFG_W-1:0]    cfg_wr_data;

    // predictor state
    logic [7:0]       asm_buf [BLOCK_BYTES];
    int unsigned      asm_fill;
    logic [7:0]       uniq_bytes [MAX_UNIQUE][BLOCK_BYTES];
    int unsigned      uniq_len [MAX_UNIQUE];
    int unsigned      uniq_cnt;
    logic [31:0]      seen_blocks;
    logic [CFG_W-1:0] size_reg;
    blk_result_t      expected_blocks [$];

    // stimulus helpers
    logic [7:0]  staged [BLOCK_BYTES];
    logic [7:0]  lib_dat [LIB_N][LIB_LEN];
    int unsigned lib_len [LIB_N];
    int unsigned lib_n;

    bit tx_idle_en   = 1'b1;
    bit rx_idle_en   = 1'b1;
    bit hold_off_req = 1'b0;
    int errors       = 0;
    int cycles       = 0;

    fixed_block_dedup_counter_unit #(
        .BLOCK_BYTES(BLOCK_BYTES),
        .MAX_UNIQUE (MAX_UNIQUE)
    ) uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_data_byte   (s_data_byte),
        .s_end_of_data (s_end_of_data),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_is_duplicate(m_is_duplicate),
        .m_unique_count(m_unique_count),
        .m_total_blocks(m_total_blocks),
        .m_block_length(m_block_length),
        .m_table_full  (m_table_full),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data)
    );

    always #6 aclk = ~aclk;

    always @(posedge aclk) begin
        cycles++;
        if (cycles == LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    function automatic int unsigned eff_size();
        if (size_reg == 0) return 1;
        if (size_reg > BLOCK_BYTES) return BLOCK_BYTES;
        return size_reg;
    endfunction

    // one accepted byte; queues the block result when the byte closes a block
    function automatic void absorb_byte(input logic [7:0] b, input logic eod);
        int unsigned len;
        bit          dup;
        bit          full;
        bit          same;
        blk_result_t r;
        if (asm_fill < BLOCK_BYTES) begin
            asm_buf[asm_fill] = b;
            asm_fill++;
        end
        if (asm_fill < eff_size() && !eod) return;
        len  = asm_fill;
        dup  = 1'b0;
        full = 1'b0;
        for (int e = 0; e < uniq_cnt && !dup; e++) begin
            if (uniq_len[e] == len) begin
                same = 1'b1;
                for (int k = 0; k < len && same; k++)
                    if (uniq_bytes[e][k] != asm_buf[k]) same = 1'b0;
                dup = same;
            end
        end
        if (!dup) begin
            if (uniq_cnt < MAX_UNIQUE) begin
                for (int k = 0; k < len; k++) uniq_bytes[uniq_cnt][k] = asm_buf[k];
                uniq_len[uniq_cnt] = len;
                uniq_cnt++;
            end else begin
                full = 1'b1;
            end
        end
        if (seen_blocks != TOTAL_MAX) seen_blocks++;
        asm_fill = 0;
        r.dup   = dup;
        r.uniq  = UCOUNT_W'(uniq_cnt);
        r.total = seen_blocks;
        r.blen  = BLEN_W'(len);
        r.full  = full;
        expected_blocks.push_back(r);
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            errors++;
        end
    endfunction

    always @(posedge aclk) begin : result_check
        blk_result_t want;
        if (aresetn === 1'b1 && m_valid === 1'b1 && m_ready === 1'b1) begin
            if (expected_blocks.size() == 0) begin
                $display("%0t: unexpected block result, expected none, got len %0d",
                         $time, m_block_length);
                errors++;
            end else begin
                want = expected_blocks.pop_front();
                check_field("is_duplicate", 32'(want.dup), 32'(m_is_duplicate));
                check_field("unique_count", 32'(want.uniq), 32'(m_unique_count));
                check_field("total_blocks", want.total, m_total_blocks);
                check_field("block_length", 32'(want.blen), 32'(m_block_length));
                check_field("table_full", 32'(want.full), 32'(m_table_full));
            end
        end
    end

    initial begin : result_ready_gen
        int stall;
        m_ready = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(posedge aclk);
            end else if (rx_idle_en && $urandom_range(0, 4) == 0) begin
                stall = $urandom_range(1, 3);
                m_ready <= 1'b0;
                repeat (stall - 1) @(posedge aclk);
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    task automatic send_item(input logic [7:0] b, input logic eod);
        int gap;
        if (tx_idle_en && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 3);
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_data_byte   <= b;
        s_end_of_data <= eod;
        @(posedge aclk);
        while (s_ready !== 1'b1) @(posedge aclk);
        absorb_byte(b, eod);
    endtask

    task automatic push_staged(input int unsigned len, input logic eod_last);
        for (int k = 0; k < len; k++)
            send_item(staged[k], eod_last && (k == len - 1));
    endtask

    task automatic wait_idle();
        s_valid <= 1'b0;
        while (expected_blocks.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic set_block_size(input logic [CFG_W-1:0] v);
        wait_idle();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        size_reg = v;
    endtask

    // reset size: a short block closed by end of data
    task automatic test_reset_size_block();
        for (int k = 0; k < SHORT_LEN; k++) staged[k] = 8'($urandom);
        staged[0]             = 8'h00;
        staged[SHORT_LEN - 1] = 8'hFF;
        push_staged(SHORT_LEN, 1'b1);
    endtask

    // size above the buffer saturates; same bytes again must be a duplicate
    task automatic test_oversize_setting();
        set_block_size(13'h1FFF);
        push_staged(SHORT_LEN, 1'b1);
        set_block_size(13'd4096);
        push_staged(3, 1'b1);
    endtask

    task automatic test_zero_size_setting();
        set_block_size(13'd0);
        send_item(8'h00, 1'b0);
        send_item(8'hFF, 1'b1);
        send_item(8'h00, 1'b0);
        send_item(8'hFF, 1'b0);
    endtask

    // zero bytes take part in the compare; length must match too
    task automatic test_zero_byte_blocks();
        set_block_size(13'd4);
        for (int k = 0; k < 4; k++) staged[k] = 8'h00;
        push_staged(4, 1'b0);
        push_staged(4, 1'b0);
        push_staged(2, 1'b1);
        push_staged(3, 1'b1);
        push_staged(2, 1'b1);
        staged[3] = 8'h01;
        push_staged(4, 1'b0);
    endtask

    // size lowered below the held byte count: next byte closes the block
    task automatic test_shrink_mid_block();
        set_block_size(13'd8);
        for (int k = 0; k < 5; k++) send_item(8'($urandom), 1'b0);
        set_block_size(13'd3);
        send_item(8'h5A, 1'b0);
    endtask

    task automatic test_output_hold_off();
        set_block_size(13'd1);
        hold_off_req = 1'b1;
        for (int k = 0; k < 24; k++) send_item(8'($urandom), 1'b0);
    endtask

    task automatic test_random_streams();
        logic [CFG_W-1:0] sizes [7] = '{13'd2, 13'd7, 13'd1, 13'd16, 13'd64, 13'd4, 13'd3};
        int unsigned eff, len, sent, roll, pick, slot, prior_cnt;
        bit          found;
        logic        eod_last;
        bit          low_entropy;
        for (int p = 0; p < 7; p++) begin
            if (p == 6) begin
                tx_idle_en = 1'b0;
                rx_idle_en = 1'b0;
            end
            set_block_size(sizes[p]);
            eff  = eff_size();
            sent = 0;
            while (sent < 200) begin
                if (asm_fill != 0) begin
                    send_item(8'($urandom), 1'b1);
                    sent++;
                end
                roll = $urandom_range(0, 9);
                if (roll == 0) begin
                    // noise: random bytes with random end flags
                    len = $urandom_range(1, eff);
                    for (int k = 0; k < len; k++)
                        send_item(8'($urandom), $urandom_range(0, 3) == 0);
                    sent += len;
                end else begin
                    found = 1'b0;
                    pick  = 0;
                    if (lib_n != 0 && roll < 5) begin
                        slot = $urandom_range(0, lib_n - 1);
                        for (int i = 0; i < lib_n && !found; i++) begin
                            if (lib_len[(slot + i) % lib_n] <= eff) begin
                                found = 1'b1;
                                pick  = (slot + i) % lib_n;
                            end
                        end
                    end
                    if (found) begin
                        len = lib_len[pick];
                        for (int k = 0; k < len; k++) staged[k] = lib_dat[pick][k];
                    end else begin
                        len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, eff) : eff;
                        low_entropy = ($urandom_range(0, 3) == 0);
                        for (int k = 0; k < len; k++)
                            staged[k] = low_entropy ? ($urandom_range(0, 1) ? 8'hFF : 8'h00)
                                                    : 8'($urandom);
                    end
                    eod_last  = (len < eff) ? 1'b1 : ($urandom_range(0, 7) == 0);
                    prior_cnt = uniq_cnt;
                    push_staged(len, eod_last);
                    sent += len;
                    // keep stored blocks around so that replays hit the table
                    if (uniq_cnt > prior_cnt && len <= LIB_LEN) begin
                        if (lib_n < LIB_N) begin
                            slot = lib_n;
                            lib_n++;
                        end else begin
                            slot = $urandom_range(0, LIB_N - 1);
                        end
                        lib_len[slot] = len;
                        for (int k = 0; k < len; k++) lib_dat[slot][k] = staged[k];
                    end
                end
            end
        end
    endtask

    initial begin
        aresetn       = 1'b0;
        s_valid       = 1'b0;
        s_data_byte   = '0;
        s_end_of_data = 1'b0;
        cfg_wr_en     = 1'b0;
        cfg_wr_data   = '0;
        asm_fill      = 0;
        uniq_cnt      = 0;
        seen_blocks   = '0;
        size_reg      = BLOCK_SIZE_RST;
        lib_n         = 0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        test_reset_size_block();
        test_oversize_setting();
        test_zero_size_setting();
        test_zero_byte_blocks();
        test_shrink_mid_block();
        test_output_hold_off();
        test_random_streams();

        wait_idle();
        if (errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

// File: sim.f
src/dfb_pkg.sv
src/dfb_ram.sv
src/dfb_scan.sv
src/fixed_block_dedup_counter_unit.sv
tb/tb_fixed_block_dedup_counter_unit.sv
